// ----- rtl/core/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, codes and helpers for the buddy block allocator core.
// ----------------------------------------------------------------------------
package bba_pkg;

   typedef enum logic [1:0] {
      NS_EMPTY = 2'd0,
      NS_ALLOC = 2'd1,
      NS_SPLIT = 2'd2,
      NS_FULL  = 2'd3
   } node_state_type;

   typedef enum logic [1:0] {
      STS_OK      = 2'd0,
      STS_NO_FIT  = 2'd1,
      STS_BAD_ADR = 2'd2
   } status_type;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic REG_POOL_LOG2    = 1'b0;
   localparam logic REG_BASE_ADDRESS = 1'b1;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_A_CHECK,
      ST_A_NEED,
      ST_A_RD,
      ST_A_EV,
      ST_A_CHAIN,
      ST_A_FAIL,
      ST_F_SUB,
      ST_F_CHK,
      ST_F_RD,
      ST_F_EV,
      ST_UP_RD,
      ST_UP_WR,
      ST_FINISH
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLR_START,
      OP_CLR_STEP,
      OP_NEED_INC,
      OP_DOWN_LEFT,
      OP_SIBLING,
      OP_UP,
      OP_ALLOC,
      OP_CLR_RIGHT,
      OP_SUB,
      OP_SET_OFF,
      OP_DESC,
      OP_FREE,
      OP_RD_SIB,
      OP_UP_WR,
      OP_RESP
   } op_type;

   typedef struct packed {
      op_type     op;
      status_type status;
   } cmd_type;

   typedef struct packed {
      logic           cmd_free;
      logic           too_large;
      logic           need_more;
      node_state_type node_st;
      logic           need_gt_lg;
      logic           lg_eq_need;
      logic           lg_at_min;
      logic           is_root;
      logic           is_left;
      logic           addr_bad;
      logic           start_match;
      logic           clr_last;
      logic           rsp_free;
      logic           pool_wr;
   } flags_type;

   function automatic logic is_full(input node_state_type s);
      return (s == NS_ALLOC) || (s == NS_FULL);
   endfunction

   function automatic node_state_type combine(input node_state_type a,
                                              input node_state_type b);
      node_state_type r;
      if (is_full(a) && is_full(b)) begin
         r = NS_FULL;
      end else if ((a != NS_EMPTY) || (b != NS_EMPTY)) begin
         r = NS_SPLIT;
      end else begin
         r = NS_EMPTY;
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/buddy_block_allocator_core.sv -----
// ----------------------------------------------------------------------------
// buddy_block_allocator_core
// Binary buddy allocator over a power-of-two pool, tree of node states.
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tuser: cmd; tdata: req_size, free_addr
// rsp      out  rsp_tvalid/rsp_tready  tuser: status; tdata: block_addr, bytes
// csr      in   csr_we                 csr_index, csr_wdata
//
// One request at a time, from acceptance to the response load. An allocation
// reads nodes down the tree, steps back after a miss, then splits levels and
// merges upward; an oversized request finishes without a tree walk. A free
// descends level by level and merges upward; a refused address stops early.
// After reset and each pool_log2 write a clearing pass over all 2^(SPAN+1)-1
// nodes (16383 by default) runs with req_tready low; a finished request holds
// until the response register frees. The node memory, with one read and one write port, sets the pace.
// ----------------------------------------------------------------------------
module buddy_block_allocator_core #(
   parameter int MAX_POOL_LOG2  = 16,
   parameter int MIN_BLOCK_LOG2 = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // req_size[31:0], free_addr[79:32]
   input  logic [0:0]  req_tuser,   // cmd[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // block_addr[47:0], allocated_bytes[64:48], zero
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   bba_pkg::cmd_type   cmd;
   bba_pkg::flags_type flags;

   bba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .flags      (flags),
      .cmd        (cmd)
   );

   bba_dp #(
      .MAX_POOL_LOG2  (MAX_POOL_LOG2),
      .MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .flags      (flags)
   );

endmodule

// ----- rtl/core/bba_ctrl.sv -----
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: tree search, free descent, merge walk, clearing and response.
// ----------------------------------------------------------------------------
module bba_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  bba_pkg::flags_type flags,
   output bba_pkg::cmd_type   cmd
);

   bba_pkg::state_type  state_ff, state_in;
   bba_pkg::status_type res_ff, res_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bba_pkg::ST_CLEAR;
         res_ff   <= bba_pkg::STS_OK;
      end else begin
         state_ff <= state_in;
         res_ff   <= res_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      res_in     = res_ff;
      cmd.op     = bba_pkg::OP_NONE;
      cmd.status = res_ff;
      req_tready = 1'b0;
      case (state_ff)
         bba_pkg::ST_CLEAR: begin
            cmd.op = bba_pkg::OP_CLR_STEP;
            if (flags.clr_last) state_in = bba_pkg::ST_IDLE;
         end
         bba_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = bba_pkg::OP_LOAD;
               state_in = bba_pkg::ST_DISPATCH;
            end
         end
         bba_pkg::ST_DISPATCH: begin
            res_in   = bba_pkg::STS_OK;
            state_in = flags.cmd_free ? bba_pkg::ST_F_SUB : bba_pkg::ST_A_CHECK;
         end
         bba_pkg::ST_A_CHECK: begin
            if (flags.too_large) begin
               res_in   = bba_pkg::STS_NO_FIT;
               state_in = bba_pkg::ST_FINISH;
            end else begin
               state_in = bba_pkg::ST_A_NEED;
            end
         end
         bba_pkg::ST_A_NEED: begin
            if (flags.need_more) cmd.op = bba_pkg::OP_NEED_INC;
            else state_in = bba_pkg::ST_A_RD;
         end
         bba_pkg::ST_A_RD: state_in = bba_pkg::ST_A_EV;
         bba_pkg::ST_A_EV: begin
            if (bba_pkg::is_full(flags.node_st)) begin
               state_in = bba_pkg::ST_A_FAIL;
            end else if (flags.node_st == bba_pkg::NS_SPLIT) begin
               if (flags.lg_at_min) begin
                  state_in = bba_pkg::ST_A_FAIL;
               end else begin
                  cmd.op   = bba_pkg::OP_DOWN_LEFT;
                  state_in = bba_pkg::ST_A_RD;
               end
            end else if (flags.need_gt_lg) begin
               state_in = bba_pkg::ST_A_FAIL;
            end else begin
               state_in = bba_pkg::ST_A_CHAIN;
            end
         end
         bba_pkg::ST_A_CHAIN: begin
            if (flags.lg_eq_need || flags.lg_at_min) begin
               cmd.op   = bba_pkg::OP_ALLOC;
               state_in = bba_pkg::ST_UP_RD;
            end else begin
               cmd.op = bba_pkg::OP_CLR_RIGHT;
            end
         end
         bba_pkg::ST_A_FAIL: begin
            if (flags.is_root) begin
               res_in   = bba_pkg::STS_NO_FIT;
               state_in = bba_pkg::ST_FINISH;
            end else if (flags.is_left) begin
               cmd.op   = bba_pkg::OP_SIBLING;
               state_in = bba_pkg::ST_A_RD;
            end else begin
               cmd.op = bba_pkg::OP_UP;
            end
         end
         bba_pkg::ST_F_SUB: begin
            cmd.op   = bba_pkg::OP_SUB;
            state_in = bba_pkg::ST_F_CHK;
         end
         bba_pkg::ST_F_CHK: begin
            if (flags.addr_bad) begin
               res_in   = bba_pkg::STS_BAD_ADR;
               state_in = bba_pkg::ST_FINISH;
            end else begin
               cmd.op   = bba_pkg::OP_SET_OFF;
               state_in = bba_pkg::ST_F_RD;
            end
         end
         bba_pkg::ST_F_RD: state_in = bba_pkg::ST_F_EV;
         bba_pkg::ST_F_EV: begin
            if (flags.node_st == bba_pkg::NS_EMPTY) begin
               res_in   = bba_pkg::STS_BAD_ADR;
               state_in = bba_pkg::ST_FINISH;
            end else if (flags.node_st == bba_pkg::NS_ALLOC) begin
               if (flags.start_match) begin
                  cmd.op   = bba_pkg::OP_FREE;
                  state_in = bba_pkg::ST_UP_RD;
               end else begin
                  res_in   = bba_pkg::STS_BAD_ADR;
                  state_in = bba_pkg::ST_FINISH;
               end
            end else if (flags.lg_at_min) begin
               res_in   = bba_pkg::STS_BAD_ADR;
               state_in = bba_pkg::ST_FINISH;
            end else begin
               cmd.op   = bba_pkg::OP_DESC;
               state_in = bba_pkg::ST_F_RD;
            end
         end
         bba_pkg::ST_UP_RD: begin
            if (flags.is_root) begin
               state_in = bba_pkg::ST_FINISH;
            end else begin
               cmd.op   = bba_pkg::OP_RD_SIB;
               state_in = bba_pkg::ST_UP_WR;
            end
         end
         bba_pkg::ST_UP_WR: begin
            cmd.op   = bba_pkg::OP_UP_WR;
            state_in = bba_pkg::ST_UP_RD;
         end
         bba_pkg::ST_FINISH: begin
            if (flags.rsp_free) begin
               cmd.op   = bba_pkg::OP_RESP;
               state_in = bba_pkg::ST_IDLE;
            end
         end
         default: state_in = bba_pkg::ST_IDLE;
      endcase
      if (flags.pool_wr) begin
         cmd.op     = bba_pkg::OP_CLR_START;
         state_in   = bba_pkg::ST_CLEAR;
         req_tready = 1'b0;
      end
   end

endmodule

// ----- rtl/core/bba_dp.sv -----
// ----------------------------------------------------------------------------
// bba_dp
// Datapath: node state memory, walk registers, byte count and response.
// ----------------------------------------------------------------------------
module bba_dp #(
   parameter int MAX_POOL_LOG2  = 16,
   parameter int MIN_BLOCK_LOG2 = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [79:0]        req_tdata,
   input  logic [0:0]         req_tuser,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [71:0]        rsp_tdata,
   output logic [1:0]         rsp_tuser,
   input  logic               csr_we,
   input  logic [0:0]         csr_index,
   input  logic [47:0]        csr_wdata,
   input  bba_pkg::cmd_type   cmd,
   output bba_pkg::flags_type flags
);

   localparam int TOP_LOG2   = (MAX_POOL_LOG2 > MIN_BLOCK_LOG2) ? MAX_POOL_LOG2
                                                                 : MIN_BLOCK_LOG2;
   localparam int SPAN       = TOP_LOG2 - MIN_BLOCK_LOG2;
   localparam int IDX_W      = SPAN + 1;
   localparam int NODE_COUNT = (1 << (SPAN + 1)) - 1;
   localparam int LG_W       = $clog2(TOP_LOG2 + 2);
   localparam int OFF_W      = TOP_LOG2;
   localparam int USED_W     = TOP_LOG2 + 1;

   bba_pkg::node_state_type mem [NODE_COUNT];
   bba_pkg::node_state_type rd_ff, s_ff, s_in;

   logic [4:0]        pool_ff;
   logic [47:0]       base_ff;
   logic              cmd_ff, cmd_in;
   logic [31:0]       size_ff, size_in;
   logic [47:0]       addr_ff, addr_in;
   logic [48:0]       rel_ff, rel_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [LG_W-1:0]   lg_ff, lg_in, need_ff, need_in;
   logic [OFF_W-1:0]  off_ff, off_in, start_ff, start_in;
   logic [USED_W-1:0] used_ff, used_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [47:0]       rsp_addr_ff, rsp_addr_in;
   logic [16:0]       rsp_bytes_ff, rsp_bytes_in;

   logic [LG_W-1:0]   p_eff;
   logic [IDX_W:0]    kid_l_w, kid_r_w;
   logic [IDX_W-1:0]  kid_l, kid_r, parent, sib, par_w, rd_addr, wr_addr;
   logic              we;
   bba_pkg::node_state_type wr_data, comb;
   logic [OFF_W-1:0]  lg_mask, half_mask;
   logic              bit_sel;
   logic [USED_W-1:0] blk_bytes;
   logic [USED_W+16:0] used_ext;

   always_comb begin
      if (int'(pool_ff) < MIN_BLOCK_LOG2) p_eff = LG_W'(MIN_BLOCK_LOG2);
      else if (int'(pool_ff) > TOP_LOG2) p_eff = LG_W'(TOP_LOG2);
      else p_eff = LG_W'(pool_ff);
   end

   assign kid_l_w   = {idx_ff, 1'b1};
   assign kid_r_w   = {idx_ff, 1'b0} + (IDX_W + 1)'(2);
   assign kid_l     = kid_l_w[IDX_W-1:0];
   assign kid_r     = kid_r_w[IDX_W-1:0];
   assign par_w     = idx_ff - IDX_W'(1);
   assign parent    = par_w >> 1;
   assign sib       = idx_ff[0] ? (idx_ff + IDX_W'(1)) : (idx_ff - IDX_W'(1));
   assign lg_mask   = OFF_W'(1) << lg_ff;
   assign half_mask = OFF_W'(1) << (lg_ff - LG_W'(1));
   assign bit_sel   = |(off_ff & half_mask);
   assign blk_bytes = USED_W'(1) << lg_ff;
   assign comb      = bba_pkg::combine(s_ff, rd_ff);
   assign used_ext  = {17'b0, used_ff};
   assign rd_addr   = (cmd.op == bba_pkg::OP_RD_SIB) ? sib : idx_ff;

   always_ff @(posedge clock) begin
      if (we) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      cmd_in        = cmd_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      rel_in        = rel_ff;
      idx_in        = idx_ff;
      lg_in         = lg_ff;
      need_in       = need_ff;
      off_in        = off_ff;
      start_in      = start_ff;
      used_in       = used_ff;
      cnt_in        = cnt_ff;
      s_in          = s_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      we            = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = bba_pkg::NS_EMPTY;
      case (cmd.op)
         bba_pkg::OP_LOAD: begin
            cmd_in   = req_tuser[0];
            size_in  = req_tdata[31:0];
            addr_in  = req_tdata[79:32];
            idx_in   = '0;
            lg_in    = p_eff;
            need_in  = LG_W'(MIN_BLOCK_LOG2);
            off_in   = '0;
            start_in = '0;
         end
         bba_pkg::OP_CLR_START: begin
            cnt_in  = '0;
            used_in = '0;
         end
         bba_pkg::OP_CLR_STEP: begin
            we      = 1'b1;
            wr_addr = cnt_ff;
            cnt_in  = cnt_ff + IDX_W'(1);
         end
         bba_pkg::OP_NEED_INC: need_in = need_ff + LG_W'(1);
         bba_pkg::OP_DOWN_LEFT: begin
            idx_in = kid_l;
            lg_in  = lg_ff - LG_W'(1);
         end
         bba_pkg::OP_SIBLING: begin
            idx_in = idx_ff + IDX_W'(1);
            off_in = off_ff + lg_mask;
         end
         bba_pkg::OP_UP: begin
            idx_in = parent;
            lg_in  = lg_ff + LG_W'(1);
            off_in = off_ff & ~lg_mask;
         end
         bba_pkg::OP_ALLOC: begin
            we      = 1'b1;
            wr_data = bba_pkg::NS_ALLOC;
            used_in = used_ff + blk_bytes;
            s_in    = bba_pkg::NS_ALLOC;
         end
         bba_pkg::OP_CLR_RIGHT: begin
            we      = 1'b1;
            wr_addr = kid_r;
            idx_in  = kid_l;
            lg_in   = lg_ff - LG_W'(1);
         end
         bba_pkg::OP_SUB: rel_in = {1'b0, addr_ff} - {1'b0, base_ff};
         bba_pkg::OP_SET_OFF: begin
            off_in   = rel_ff[OFF_W-1:0];
            start_in = '0;
         end
         bba_pkg::OP_DESC: begin
            if (bit_sel) start_in = start_ff | half_mask;
            idx_in = bit_sel ? kid_r : kid_l;
            lg_in  = lg_ff - LG_W'(1);
         end
         bba_pkg::OP_FREE: begin
            we      = 1'b1;
            used_in = (used_ff >= blk_bytes) ? (used_ff - blk_bytes) : '0;
            s_in    = bba_pkg::NS_EMPTY;
         end
         bba_pkg::OP_UP_WR: begin
            we      = 1'b1;
            wr_addr = parent;
            wr_data = comb;
            s_in    = comb;
            idx_in  = parent;
         end
         bba_pkg::OP_RESP: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = cmd.status;
            rsp_bytes_in  = used_ext[16:0];
            rsp_addr_in   = ((cmd_ff == bba_pkg::CMD_ALLOC) && (cmd.status == bba_pkg::STS_OK))
                            ? (base_ff + 48'(off_ff)) : '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff      <= 5'd16;
         base_ff      <= '0;
         used_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && (csr_index == bba_pkg::REG_POOL_LOG2)) pool_ff <= csr_wdata[4:0];
         if (csr_we && (csr_index == bba_pkg::REG_BASE_ADDRESS)) base_ff <= csr_wdata;
         used_ff      <= used_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      rel_ff        <= rel_in;
      idx_ff        <= idx_in;
      lg_ff         <= lg_in;
      need_ff       <= need_in;
      off_ff        <= off_in;
      start_ff      <= start_in;
      s_ff          <= s_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_bytes_ff  <= rsp_bytes_in;
   end

   always_comb begin
      flags.cmd_free    = (cmd_ff == bba_pkg::CMD_FREE);
      flags.too_large   = {1'b0, size_ff} > (33'(1) << p_eff);
      flags.need_more   = (need_ff < p_eff) && ((33'(1) << need_ff) < {1'b0, size_ff});
      flags.node_st     = rd_ff;
      flags.need_gt_lg  = need_ff > lg_ff;
      flags.lg_eq_need  = need_ff == lg_ff;
      flags.lg_at_min   = lg_ff <= LG_W'(MIN_BLOCK_LOG2);
      flags.is_root     = idx_ff == '0;
      flags.is_left     = idx_ff[0];
      flags.addr_bad    = rel_ff[48] || ((rel_ff[47:0] >> p_eff) != 48'd0);
      flags.start_match = start_ff == off_ff;
      flags.clr_last    = cnt_ff == IDX_W'(NODE_COUNT - 1);
      flags.rsp_free    = !rsp_valid_ff || rsp_tready;
      flags.pool_wr     = csr_we && (csr_index == bba_pkg::REG_POOL_LOG2);
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'b0, rsp_bytes_ff, rsp_addr_ff};

endmodule

// ----- tb/sv/buddy_block_allocator_core_test.sv -----
// ----------------------------------------------------------------------------
// buddy_block_allocator_core_test
// Self-checking bench for the buddy allocator: a mirror of the node tree
// predicts status, address and byte count for every request, over several
// pool sizes and base addresses, with random idling on both channels.
// ----------------------------------------------------------------------------
module buddy_block_allocator_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TOP_LOG2 = 16;
   localparam int MIN_LOG2 = 3;
   localparam int SPAN     = TOP_LOG2 - MIN_LOG2;
   localparam int NODES    = (1 << (SPAN + 1)) - 1;
   localparam longint LIMIT = 40000000;

   typedef struct {
      bba_pkg::status_type status;
      logic [47:0]         block_addr;
      logic [16:0]         bytes;
   } alloc_result_type;

   class pool_mirror_type;
      bba_pkg::node_state_type tree[NODES];
      int unsigned      used;
      logic [4:0]       pool_reg;
      logic [47:0]      base;
      alloc_result_type pending[$];
      logic [47:0]      live[$];
      int               n_fail;

      function void clear_pool();
         foreach (tree[i]) tree[i] = bba_pkg::NS_EMPTY;
         used = 0;
         live.delete();
      endfunction

      function void reset_state();
         pool_reg = 5'd16;
         base     = '0;
         clear_pool();
      endfunction

      function void write_reg(logic idx, logic [47:0] val);
         if (idx == bba_pkg::REG_POOL_LOG2) begin
            pool_reg = val[4:0];
            clear_pool();
         end else begin
            base = val;
         end
      endfunction

      function int eff_log2();
         if (pool_reg < MIN_LOG2) return MIN_LOG2;
         if (pool_reg > TOP_LOG2) return TOP_LOG2;
         return pool_reg;
      endfunction

      function bit full_st(bba_pkg::node_state_type s);
         return (s == bba_pkg::NS_ALLOC) || (s == bba_pkg::NS_FULL);
      endfunction

      function bba_pkg::node_state_type merged(int idx);
         int l;
         l = 2 * idx + 1;
         if (l + 1 >= NODES) return bba_pkg::NS_EMPTY;
         if (full_st(tree[l]) && full_st(tree[l+1])) return bba_pkg::NS_FULL;
         if (tree[l] != bba_pkg::NS_EMPTY || tree[l+1] != bba_pkg::NS_EMPTY)
            return bba_pkg::NS_SPLIT;
         return bba_pkg::NS_EMPTY;
      endfunction

      function bit take_block(int idx, int lg, int off, int need, output int where);
         int l;
         bit ok;
         l = 2 * idx + 1;
         where = 0;
         if (idx >= NODES) return 0;
         if (full_st(tree[idx])) return 0;
         if (tree[idx] == bba_pkg::NS_SPLIT) begin
            if (lg <= MIN_LOG2 || l + 1 >= NODES) return 0;
            ok = take_block(l, lg - 1, off, need, where);
            if (!ok) ok = take_block(l + 1, lg - 1, off + (1 << (lg - 1)), need, where);
            tree[idx] = merged(idx);
            return ok;
         end
         if (need > lg) return 0;
         if (lg > need && lg > MIN_LOG2 && l + 1 < NODES) begin
            tree[l] = bba_pkg::NS_EMPTY;
            tree[l+1] = bba_pkg::NS_EMPTY;
            ok = take_block(l, lg - 1, off, need, where);
            tree[idx] = merged(idx);
            return ok;
         end
         tree[idx] = bba_pkg::NS_ALLOC;
         used += 1 << lg;
         where = off;
         return 1;
      endfunction

      function bba_pkg::status_type release_block(logic [47:0] addr);
         int p, idx, lg, depth, start, off, b;
         int path[SPAN+1];
         logic [47:0] rel;
         p = eff_log2();
         if (addr < base) return bba_pkg::STS_BAD_ADR;
         rel = addr - base;
         if (rel >= (48'd1 << p)) return bba_pkg::STS_BAD_ADR;
         off = rel; lg = p; idx = 0; depth = 0; start = 0;
         forever begin
            if (tree[idx] == bba_pkg::NS_EMPTY) return bba_pkg::STS_BAD_ADR;
            if (tree[idx] == bba_pkg::NS_ALLOC) break;
            if (lg <= MIN_LOG2 || depth >= SPAN || 2 * idx + 2 >= NODES)
               return bba_pkg::STS_BAD_ADR;
            path[depth++] = idx;
            b = (off >> (lg - 1)) & 1;
            if (b) start += 1 << (lg - 1);
            idx = 2 * idx + 1 + b;
            lg--;
         end
         if (start != off) return bba_pkg::STS_BAD_ADR;
         tree[idx] = bba_pkg::NS_EMPTY;
         used = (used >= (1 << lg)) ? used - (1 << lg) : 0;
         for (int k = depth; k > 0; k--) tree[path[k-1]] = merged(path[k-1]);
         foreach (live[i]) if (live[i] == addr) begin
            live.delete(i);
            break;
         end
         return bba_pkg::STS_OK;
      endfunction

      function void accept_request(logic cmd, logic [31:0] size, logic [47:0] faddr);
         alloc_result_type r;
         int p, need, where;
         r.block_addr = '0;
         if (cmd == bba_pkg::CMD_ALLOC) begin
            p = eff_log2();
            need = MIN_LOG2;
            if (size > (33'd1 << p)) begin
               r.status = bba_pkg::STS_NO_FIT;
            end else begin
               while (need < p && (33'd1 << need) < size) need++;
               if (take_block(0, p, 0, need, where)) begin
                  r.status = bba_pkg::STS_OK;
                  r.block_addr = base + where;
                  live.push_back(r.block_addr);
               end else begin
                  r.status = bba_pkg::STS_NO_FIT;
               end
            end
         end else begin
            r.status = release_block(faddr);
         end
         r.bytes = used[16:0];
         pending.push_back(r);
      endfunction

      function void check_response(logic [1:0] sts, logic [47:0] addr, logic [16:0] bytes);
         alloc_result_type e;
         if (pending.size() == 0) begin
            $error("response with nothing outstanding: status %0d addr %h", sts, addr);
            n_fail++;
            return;
         end
         e = pending.pop_front();
         if (sts != e.status) begin
            $error("status: expected %0d, got %0d", e.status, sts);
            n_fail++;
         end
         if (addr != e.block_addr) begin
            $error("block_addr: expected %h, got %h", e.block_addr, addr);
            n_fail++;
         end
         if (bytes != e.bytes) begin
            $error("allocated_bytes: expected %0d, got %0d", e.bytes, bytes);
            n_fail++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;   // req_size[31:0], free_addr[79:32]
   logic [0:0]  req_tuser = '0;   // cmd[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // block_addr[47:0], allocated_bytes[64:48], zero
   logic [1:0]  rsp_tuser;        // status[1:0]
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [47:0] csr_wdata = '0;

   pool_mirror_type mirror = new();
   bit              calm = 0;
   bit              long_hold = 0;
   longint          cycles = 0;

   buddy_block_allocator_core dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         mirror.check_response(rsp_tuser, rsp_tdata[47:0], rsp_tdata[64:48]);
   end

   initial begin
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (600) @(posedge clock);
            long_hold = 0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (mirror.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [47:0] val);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      mirror.write_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic send_request(logic cmd, logic [31:0] size, logic [47:0] faddr);
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {faddr, size};
      do @(posedge clock); while (!req_tready);
      mirror.accept_request(cmd, size, faddr);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic random_request();
      int p, pick;
      logic [47:0] a;
      p = mirror.eff_log2();
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         send_request(bba_pkg::CMD_ALLOC, $urandom_range(0, 1 << $urandom_range(0, p)), '0);
      end else if (pick < 85 && mirror.live.size() != 0) begin
         a = mirror.live[$urandom_range(0, mirror.live.size() - 1)];
         send_request(bba_pkg::CMD_FREE, $urandom, ($urandom_range(0, 9) == 0) ? a + 8 : a);
      end else if (pick < 92) begin
         send_request(bba_pkg::CMD_ALLOC, $urandom, {$urandom, $urandom});
      end else begin
         a = {$urandom, $urandom};
         if ($urandom_range(0, 1)) a = mirror.base + $urandom_range(0, (1 << p) - 1);
         send_request(bba_pkg::CMD_FREE, $urandom, a);
      end
   endtask

   logic [4:0]  pools[7] = '{5'd3, 5'd0, 5'd31, 5'd6, 5'd10, 5'd16, 5'd8};
   logic [47:0] bases[7] = '{48'hFFFF_FFFF_FFF8, 48'h1234, 48'h0, 48'hFFFF_FFFF_FFFF,
                             48'h8000_0000_0000, 48'h0, 48'h5A5A_5A5A_0000};

   initial begin
      mirror.reset_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (!req_tready) @(posedge clock);

      // default pool, then a moved base and a 2^4-byte pool: size extremes, rounding, frees good and bad
      send_request(bba_pkg::CMD_ALLOC, 32'd0, '0);
      send_request(bba_pkg::CMD_ALLOC, 32'd1, '0);
      send_request(bba_pkg::CMD_ALLOC, 32'd8, '0);
      send_request(bba_pkg::CMD_ALLOC, 32'd9, '0);
      send_request(bba_pkg::CMD_ALLOC, 32'd65537, '0);
      send_request(bba_pkg::CMD_ALLOC, 32'hFFFF_FFFF, '0);
      send_request(bba_pkg::CMD_ALLOC, 32'd4096, '0);
      send_request(bba_pkg::CMD_FREE, '0, 48'd8);
      send_request(bba_pkg::CMD_FREE, '0, 48'd8);
      send_request(bba_pkg::CMD_FREE, '0, 48'd12);
      send_request(bba_pkg::CMD_FREE, '0, 48'h1_0000);
      send_request(bba_pkg::CMD_FREE, '0, 48'hFFFF_FFFF_FFFF);
      send_request(bba_pkg::CMD_FREE, '0, 48'd0);
      send_request(bba_pkg::CMD_ALLOC, 32'd65536, '0);
      send_request(bba_pkg::CMD_ALLOC, 32'd32768, '0);
      write_csr(bba_pkg::REG_BASE_ADDRESS, 48'h100);
      send_request(bba_pkg::CMD_ALLOC, 32'd16, '0);
      send_request(bba_pkg::CMD_FREE, '0, 48'h0F8);
      send_request(bba_pkg::CMD_FREE, '0, 48'h0);
      write_csr(bba_pkg::REG_POOL_LOG2, 48'hABCD_0000_0004);
      send_request(bba_pkg::CMD_ALLOC, 32'd16, '0);
      send_request(bba_pkg::CMD_ALLOC, 32'd17, '0);
      send_request(bba_pkg::CMD_ALLOC, 32'd8, '0);
      send_request(bba_pkg::CMD_ALLOC, 32'd8, '0);
      send_request(bba_pkg::CMD_ALLOC, 32'd8, '0);

      for (int ph = 0; ph < 7; ph++) begin
         write_csr(bba_pkg::REG_POOL_LOG2, {43'd0, pools[ph]});
         write_csr(bba_pkg::REG_BASE_ADDRESS, bases[ph]);
         while (!req_tready) @(posedge clock);
         if (ph == 1) long_hold = 1;
         if (ph == 6) calm = 1;
         for (int n = 0; n < 205; n++) random_request();
      end
      req_tvalid <= 1'b0;

      wait_idle();
      repeat (50) @(posedge clock);
      if (mirror.n_fail == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

// ----- files.f -----
rtl/core/bba_pkg.sv
rtl/core/bba_ctrl.sv
rtl/core/bba_dp.sv
rtl/core/buddy_block_allocator_core.sv
tb/sv/buddy_block_allocator_core_test.sv
